[design/tld_pkg.sv]
// ----------------------------------------------------------------------------
// Trajectory densifier package
// Shared widths, constants, command and status structures and the step
// function of the lane dividers.
// ----------------------------------------------------------------------------
package tld_pkg;

	localparam int MAX_SEGS  = 63;
	localparam int SEG_W     = 6;
	localparam int RES_W     = 20;
	localparam int LANES     = 5;
	localparam int EXT_W     = 34;
	localparam int MAG_W     = 33;
	localparam int DIV_BITS  = 3;
	localparam int DIV_STEPS = MAG_W / DIV_BITS;
	localparam logic [RES_W-1:0] RES_RESET = RES_W'(10000);

	localparam int LANE_X = 0;
	localparam int LANE_Y = 1;
	localparam int LANE_H = 2;
	localparam int LANE_S = 3;
	localparam int LANE_T = 4;

	// Commands from the sequencer to the datapath.
	typedef struct packed {
		logic       load;
		logic       seg_init;
		logic       seg_step;
		logic [2:0] bit_idx;
		logic       div_init;
		logic       div_step;
		logic       emit_prev;
		logic       emit_int;
		logic       emit_cur;
		logic       run_last;
		logic       store;
		logic       clear;
	} cmd_t;

	// Status from the datapath to the sequencer.
	typedef struct packed {
		logic             have_prev;
		logic             last;
		logic             dt_pos;
		logic [SEG_W-1:0] segs;
		logic             out_free;
	} sts_t;

	typedef struct packed {
		logic [SEG_W-1:0] rem;
		logic [MAG_W-1:0] dvd;
	} div_t;

	// Three restoring division steps; the quotient bits shift into the dividend.
	function automatic div_t div_step3(div_t d, logic [SEG_W-1:0] segs);
		div_t        r;
		logic [SEG_W:0] r7;
		logic        ge;
		r = d;
		for (int k = 0; k < DIV_BITS; k++) begin
			r7 = {r.rem, r.dvd[MAG_W-1]};
			ge = (r7 >= {1'b0, segs});
			if (ge) begin
				r.rem = SEG_W'(r7 - {1'b0, segs});
			end else begin
				r.rem = r7[SEG_W-1:0];
			end
			r.dvd = {r.dvd[MAG_W-2:0], ge};
		end
		return r;
	endfunction

endpackage

[design/tld_ctrl.sv]
// ----------------------------------------------------------------------------
// Trajectory densifier sequencer
// Steps each accepted point through the segment divide, the lane divides and
// the emission of the stored, interpolated and final points.
// ----------------------------------------------------------------------------
module tld_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  tld_pkg::sts_t sts,
	output tld_pkg::cmd_t cmd
);
	import tld_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CHECK = 3'd1;
	localparam logic [2:0] ST_SEG   = 3'd2;
	localparam logic [2:0] ST_DINIT = 3'd3;
	localparam logic [2:0] ST_DIV   = 3'd4;
	localparam logic [2:0] ST_PREV  = 3'd5;
	localparam logic [2:0] ST_INT   = 3'd6;
	localparam logic [2:0] ST_CUR   = 3'd7;

	logic [2:0]       state_q, state_d;
	logic [3:0]       cnt_q, cnt_d;
	logic [SEG_W-1:0] j_q, j_d;
	logic             interp_any;
	logic             j_end;

	assign in_ready   = (state_q == ST_IDLE);
	assign interp_any = sts.dt_pos && (sts.segs != SEG_W'(1));
	assign j_end      = (j_q == SEG_W'(sts.segs - SEG_W'(1)));

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		j_d     = j_q;
		cmd     = '0;
		cmd.bit_idx = cnt_q[2:0];
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (!sts.have_prev) begin
					if (sts.last) begin
						state_d = ST_CUR;
					end else begin
						cmd.store = 1'b1;
						state_d   = ST_IDLE;
					end
				end else if (sts.dt_pos) begin
					cmd.seg_init = 1'b1;
					cnt_d        = 4'(SEG_W - 1);
					state_d      = ST_SEG;
				end else begin
					state_d = ST_PREV;
				end
			end
			ST_SEG: begin
				cmd.seg_step = 1'b1;
				cnt_d        = cnt_q - 4'd1;
				if (cnt_q == 4'd0) begin
					state_d = ST_DINIT;
				end
			end
			ST_DINIT: begin
				cmd.div_init = 1'b1;
				cnt_d        = 4'(DIV_STEPS - 1);
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q - 4'd1;
				if (cnt_q == 4'd0) begin
					state_d = ST_PREV;
				end
			end
			ST_PREV: begin
				if (sts.out_free) begin
					cmd.emit_prev = 1'b1;
					cmd.run_last  = !sts.last && !interp_any;
					j_d           = SEG_W'(1);
					if (interp_any) begin
						state_d = ST_INT;
					end else if (sts.last) begin
						state_d = ST_CUR;
					end else begin
						cmd.store = 1'b1;
						state_d   = ST_IDLE;
					end
				end
			end
			ST_INT: begin
				if (sts.out_free) begin
					cmd.emit_int = 1'b1;
					cmd.run_last = !sts.last && j_end;
					j_d          = j_q + SEG_W'(1);
					if (j_end) begin
						if (sts.last) begin
							state_d = ST_CUR;
						end else begin
							cmd.store = 1'b1;
							state_d   = ST_IDLE;
						end
					end
				end
			end
			ST_CUR: begin
				if (sts.out_free) begin
					cmd.emit_cur = 1'b1;
					cmd.run_last = 1'b1;
					cmd.clear    = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			j_q     <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			j_q     <= j_d;
		end
	end

endmodule

[design/tld_datapath.sv]
// ----------------------------------------------------------------------------
// Trajectory densifier datapath
// Holds the stored and current points, the segment divider, five lane
// dividers with their running quotients, and the output register.
// ----------------------------------------------------------------------------
module tld_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  tld_pkg::cmd_t                  cmd,
	output tld_pkg::sts_t                  sts,
	input  logic                           cfg_we,
	input  logic [tld_pkg::RES_W-1:0]      cfg_wdata,
	input  logic signed [31:0]             pos_x,
	input  logic signed [31:0]             pos_y,
	input  logic signed [15:0]             heading,
	input  logic signed [15:0]             speed,
	input  logic [31:0]                    time_us,
	input  logic                           last_point,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [31:0]             out_x,
	output logic signed [31:0]             out_y,
	output logic signed [15:0]             out_heading,
	output logic signed [15:0]             out_speed,
	output logic [31:0]                    out_time_us,
	output logic                           interpolated,
	output logic                           run_last
);
	import tld_pkg::*;

	logic [RES_W-1:0] res_q;
	logic             have_prev_q;
	logic signed [31:0] prev_x_q, prev_y_q, cur_x_q, cur_y_q;
	logic signed [15:0] prev_h_q, prev_s_q, cur_h_q, cur_s_q;
	logic [31:0]        prev_t_q, cur_t_q;
	logic               last_q;

	logic [RES_W-1:0] res_eff;
	logic [32:0]      dt;
	logic             dt_pos;
	logic [31:0]      rem_q;
	logic [SEG_W-1:0] seg_q;
	logic             sat_q;
	logic [SEG_W-1:0] segs;
	logic [31:0]      trial;

	logic [EXT_W-1:0] prev_ext [LANES];
	logic [EXT_W-1:0] cur_ext  [LANES];
	logic [EXT_W-1:0] val      [LANES];
	logic [MAG_W-1:0] acc_n    [LANES];
	logic [SEG_W-1:0] accr_n   [LANES];
	logic             neg_q    [LANES];
	div_t             div_q    [LANES];
	logic [MAG_W-1:0] acc_q    [LANES];
	logic [SEG_W-1:0] accr_q   [LANES];

	logic               out_valid_q;
	logic signed [31:0] out_x_q, out_y_q;
	logic signed [15:0] out_h_q, out_s_q;
	logic [31:0]        out_t_q;
	logic               interp_q, run_last_q;
	logic               emit;

	// Resolution register; zero behaves as one microsecond.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= RES_RESET;
		end else if (cfg_we) begin
			res_q <= cfg_wdata;
		end
	end
	assign res_eff = (res_q == '0) ? RES_W'(1) : res_q;

	// Stored point presence flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q <= 1'b0;
		end else if (cmd.clear) begin
			have_prev_q <= 1'b0;
		end else if (cmd.store) begin
			have_prev_q <= 1'b1;
		end
	end

	// Current and stored points.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q <= '0;
			prev_y_q <= '0;
			prev_h_q <= '0;
			prev_s_q <= '0;
			prev_t_q <= '0;
		end else if (cmd.clear) begin
			prev_x_q <= '0;
			prev_y_q <= '0;
			prev_h_q <= '0;
			prev_s_q <= '0;
			prev_t_q <= '0;
		end else if (cmd.store) begin
			prev_x_q <= cur_x_q;
			prev_y_q <= cur_y_q;
			prev_h_q <= cur_h_q;
			prev_s_q <= cur_s_q;
			prev_t_q <= cur_t_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_x_q <= pos_x;
			cur_y_q <= pos_y;
			cur_h_q <= heading;
			cur_s_q <= speed;
			cur_t_q <= time_us;
			last_q  <= last_point;
		end
	end

	// Signed time gap and segment count: ceil(gap / res) = floor((gap-1)/res)+1.
	assign dt     = {1'b0, cur_t_q} - {1'b0, prev_t_q};
	assign dt_pos = !dt[32] && (dt != '0);
	assign trial  = {{(32-RES_W){1'b0}}, res_eff} << cmd.bit_idx;

	always_ff @(posedge clk) begin
		if (cmd.seg_init) begin
			rem_q <= dt[31:0] - 32'd1;
			seg_q <= '0;
			sat_q <= ((dt[31:0] - 32'd1) >= {{(32-RES_W-SEG_W){1'b0}}, res_eff, {SEG_W{1'b0}}});
		end else if (cmd.seg_step) begin
			if (rem_q >= trial) begin
				rem_q             <= rem_q - trial;
				seg_q[cmd.bit_idx] <= 1'b1;
			end
		end
	end

	assign segs = (sat_q || (seg_q == SEG_W'(MAX_SEGS))) ? SEG_W'(MAX_SEGS)
	                                                     : seg_q + SEG_W'(1);

	// Lane operands: signed fields sign-extend, the timestamp zero-extends.
	assign prev_ext[LANE_X] = EXT_W'(prev_x_q);
	assign prev_ext[LANE_Y] = EXT_W'(prev_y_q);
	assign prev_ext[LANE_H] = EXT_W'(prev_h_q);
	assign prev_ext[LANE_S] = EXT_W'(prev_s_q);
	assign prev_ext[LANE_T] = {{(EXT_W-32){1'b0}}, prev_t_q};
	assign cur_ext[LANE_X]  = EXT_W'(cur_x_q);
	assign cur_ext[LANE_Y]  = EXT_W'(cur_y_q);
	assign cur_ext[LANE_H]  = EXT_W'(cur_h_q);
	assign cur_ext[LANE_S]  = EXT_W'(cur_s_q);
	assign cur_ext[LANE_T]  = {{(EXT_W-32){1'b0}}, cur_t_q};

	// Each lane divides |cur-prev| by segs, then keeps j*|d|/segs as a running
	// quotient and remainder so that every step is one add and compare.
	for (genvar i = 0; i < LANES; i++) begin : g_lane
		logic [EXT_W-1:0] diff;
		logic [EXT_W-1:0] mag;
		logic [SEG_W:0]   s7;
		logic             carry;
		assign diff     = cur_ext[i] - prev_ext[i];
		assign mag      = diff[EXT_W-1] ? (~diff + EXT_W'(1)) : diff;
		assign s7       = {1'b0, accr_q[i]} + {1'b0, div_q[i].rem};
		assign carry    = (s7 >= {1'b0, segs});
		assign accr_n[i] = carry ? SEG_W'(s7 - {1'b0, segs}) : s7[SEG_W-1:0];
		assign acc_n[i]  = acc_q[i] + div_q[i].dvd + MAG_W'(carry);
		assign val[i]    = neg_q[i] ? (prev_ext[i] - {1'b0, acc_n[i]})
		                            : (prev_ext[i] + {1'b0, acc_n[i]});

		always_ff @(posedge clk) begin
			if (cmd.div_init) begin
				neg_q[i]     <= diff[EXT_W-1];
				div_q[i].rem <= '0;
				div_q[i].dvd <= mag[MAG_W-1:0];
				acc_q[i]     <= '0;
				accr_q[i]    <= '0;
			end else if (cmd.div_step) begin
				div_q[i] <= div_step3(div_q[i], segs);
			end else if (cmd.emit_int) begin
				acc_q[i]  <= acc_n[i];
				accr_q[i] <= accr_n[i];
			end
		end
	end

	// Output register: loads one beat whenever the slot is free.
	assign emit = cmd.emit_prev || cmd.emit_int || cmd.emit_cur;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_prev) begin
			out_x_q  <= prev_x_q;
			out_y_q  <= prev_y_q;
			out_h_q  <= prev_h_q;
			out_s_q  <= prev_s_q;
			out_t_q  <= prev_t_q;
			interp_q <= 1'b0;
		end else if (cmd.emit_int) begin
			out_x_q  <= val[LANE_X][31:0];
			out_y_q  <= val[LANE_Y][31:0];
			out_h_q  <= val[LANE_H][15:0];
			out_s_q  <= val[LANE_S][15:0];
			out_t_q  <= val[LANE_T][31:0];
			interp_q <= 1'b1;
		end else if (cmd.emit_cur) begin
			out_x_q  <= cur_x_q;
			out_y_q  <= cur_y_q;
			out_h_q  <= cur_h_q;
			out_s_q  <= cur_s_q;
			out_t_q  <= cur_t_q;
			interp_q <= 1'b0;
		end
		if (emit) begin
			run_last_q <= cmd.run_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_x        = out_x_q;
	assign out_y        = out_y_q;
	assign out_heading  = out_h_q;
	assign out_speed    = out_s_q;
	assign out_time_us  = out_t_q;
	assign interpolated = interp_q;
	assign run_last     = run_last_q;

	// Status back to the sequencer.
	assign sts.have_prev = have_prev_q;
	assign sts.last      = last_q;
	assign sts.dt_pos    = dt_pos;
	assign sts.segs      = segs;
	assign sts.out_free  = !out_valid_q || out_ready;

endmodule

[design/trajectory_linear_densifier_unit.sv]
// ----------------------------------------------------------------------------
// Trajectory linear densifier
// Inserts linearly interpolated points between successive trajectory points.
// ----------------------------------------------------------------------------
// Points enter on the in_valid/in_ready channel, one beat per point. Each
// point that follows a stored one releases the stored point and then segs-1
// interpolated points on the out_valid/out_ready channel, where segs is the
// time gap over cfg resolution, rounded up and limited to 63. A point marked
// last_point is also released itself and the stored point is dropped.
// A point is worked on alone: acceptance, a check state, then for a
// positive gap the segment division (one quotient bit per cycle), a
// set-up state and the lane division, in which five lane dividers each
// retire three bits per step, after which one result beat leaves per
// cycle while the receiver does not stall. in_ready is high only between
// points. The output register holds one beat; when the receiver stalls
// the sequencer waits and no beat is lost. Reset clears the stored point,
// empties the output register and sets the resolution to 10000 us. The
// user writes the resolution through cfg_we/cfg_wdata only while idle;
// the block does not enforce this.
// ----------------------------------------------------------------------------
module trajectory_linear_densifier_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [tld_pkg::RES_W-1:0] cfg_wdata,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [31:0]        pos_x,
	input  logic signed [31:0]        pos_y,
	input  logic signed [15:0]        heading,
	input  logic signed [15:0]        speed,
	input  logic [31:0]               time_us,
	input  logic                      last_point,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [31:0]        out_x,
	output logic signed [31:0]        out_y,
	output logic signed [15:0]        out_heading,
	output logic signed [15:0]        out_speed,
	output logic [31:0]               out_time_us,
	output logic                      interpolated,
	output logic                      run_last
);
	import tld_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Sequencer.
	tld_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath.
	tld_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.heading      (heading),
		.speed        (speed),
		.time_us      (time_us),
		.last_point   (last_point),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_x        (out_x),
		.out_y        (out_y),
		.out_heading  (out_heading),
		.out_speed    (out_speed),
		.out_time_us  (out_time_us),
		.interpolated (interpolated),
		.run_last     (run_last)
	);

endmodule
